FILE: rtl/modular_exponentiation_assert.svh
// assertion macros used by the modular exponentiation port checker
// needs clk and arst_n in the scope where a macro is used
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MEXP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modular exponentiation check failed");

// consequent must hold in the cycle after the antecedent
`define MEXP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modular exponentiation check failed");

`endif

FILE: rtl/mexp_pkg.sv
// shared constants and types of the modular exponentiation block
// no dependencies
package mexp_pkg;

	// operand width of the arithmetic, low bits of every field
	localparam int WORD_BITS = 32;
	// width of the stream data and configuration data
	localparam int DATA_BITS = 32;
	// step counter of the multiplier, holds WORD_BITS itself
	localparam int CNT_BITS = $clog2(WORD_BITS + 1);
	// configuration register indexes
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = 1'b1;

	// request to the modular multiplier: a * b mod m
	typedef struct packed {
		logic                 start;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		logic [WORD_BITS-1:0] m;
	} mexp_mul_req_t;

	// response of the modular multiplier
	typedef struct packed {
		logic                 done;
		logic [WORD_BITS-1:0] prod;
	} mexp_mul_rsp_t;

endpackage

FILE: rtl/mexp_mulmod.sv
// shift-add modular multiplier, one multiplier bit per cycle, msb first
// depends on mexp_pkg
module mexp_mulmod (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mexp_pkg::mexp_mul_req_t req,
	output mexp_pkg::mexp_mul_rsp_t rsp
);
	import mexp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] r_q;

	logic                 m_zero;
	logic [WORD_BITS:0]   dbl;
	logic [WORD_BITS:0]   dbl_sub;
	logic [WORD_BITS-1:0] dbl_red;
	logic [WORD_BITS-1:0] addend;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS:0]   sum_sub;
	logic [WORD_BITS-1:0] r_next;

	// r = (2r + bit * b) mod m, modulus zero wraps at the word width
	always_comb begin
		m_zero  = (m_q == '0);
		dbl     = {r_q, 1'b0};
		dbl_sub = dbl - {1'b0, m_q};
		if (!m_zero && (dbl >= {1'b0, m_q})) begin
			dbl_red = dbl_sub[WORD_BITS-1:0];
		end else begin
			dbl_red = dbl[WORD_BITS-1:0];
		end
		addend  = a_q[WORD_BITS-1] ? b_q : '0;
		sum     = {1'b0, dbl_red} + {1'b0, addend};
		sum_sub = sum - {1'b0, m_q};
		if (!m_zero && (sum >= {1'b0, m_q})) begin
			r_next = sum_sub[WORD_BITS-1:0];
		end else begin
			r_next = sum[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[WORD_BITS-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = r_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// modular exponentiation top level: stream ports, configuration and sequencer
// depends on mexp_pkg and mexp_mulmod
//
// Each input beat carries a base; the block returns base ** exponent mod modulus
// as one output beat, using right-to-left square-and-multiply. modulus and
// exponent are configuration registers (index 0 and 1, reset to 1 and 0) and
// are written over the cfg channel, which is always ready; write them only while
// no beat is in flight. All arithmetic runs on one shared shift-add modular
// multiplier that retires one multiplier bit per cycle. An item first reduces
// the base (one multiplication), then does one squaring for each exponent bit
// below the highest set bit and one multiply for each set bit: N = L + P
// multiplications, with L the position of the highest set exponent bit counted
// from one and P the number of set bits (N = 1 for exponent zero).
// s_axis_tready is low from the base beat until the result has gone into the
// output register and the sequencer is back in ST_IDLE. An exponent of zero
// returns 1 even for modulus 1; a modulus of zero reduces by wraparound at
// WORD_BITS. The result sits in an output register, so a new base is taken
// while an earlier result still waits on m_axis_tready.
module modular_exponentiation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream, tdata: base_value
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [mexp_pkg::DATA_BITS-1:0]       s_axis_tdata,
	// output stream, tdata: power_result
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [mexp_pkg::DATA_BITS-1:0]       m_axis_tdata,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mexp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [mexp_pkg::DATA_BITS-1:0]       cfg_data
);
	import mexp_pkg::*;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,  // waiting for a base beat
		ST_RED  = 6'b000010,  // reducing the base mod modulus
		ST_STEP = 6'b000100,  // picking the next operation from the exponent
		ST_MUL  = 6'b001000,  // acc * base power
		ST_SQR  = 6'b010000,  // squaring the base power
		ST_HOLD = 6'b100000   // result ready, output register still full
	} state_t;

	state_t               state_q;
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] exponent_q;
	logic [WORD_BITS-1:0] exp_q;     // exponent bits still to handle
	logic [WORD_BITS-1:0] acc_q;     // running product
	logic [WORD_BITS-1:0] pow_q;     // base raised to 2**i
	logic [WORD_BITS-1:0] out_q;
	logic                 out_valid_q;

	mexp_mul_req_t mul_req;
	mexp_mul_rsp_t mul_rsp;

	logic in_beat;
	logic out_beat;
	logic out_free;
	logic finish;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;
	// output register can take a result in this cycle
	assign out_free = !out_valid_q || m_axis_tready;
	// exponent exhausted, acc holds the answer
	assign finish   = ((state_q == ST_STEP) && (exp_q == '0)) || (state_q == ST_HOLD);

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// multiplier operands follow the sequencer state
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = pow_q;
		mul_req.b     = pow_q;
		mul_req.m     = modulus_q;
		case (state_q)
			ST_IDLE: begin
				// base * 1 mod m reduces the base
				mul_req.start = in_beat;
				mul_req.a     = s_axis_tdata[WORD_BITS-1:0];
				mul_req.b     = WORD_BITS'(1);
			end
			ST_STEP: begin
				mul_req.start = (exp_q != '0);
				if (exp_q[0]) begin
					mul_req.a = acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers, writes beyond the list fall through
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(1);
			exponent_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODULUS:  modulus_q  <= cfg_data[WORD_BITS-1:0];
				CFG_EXPONENT: exponent_q <= cfg_data[WORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			exp_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						exp_q   <= exponent_q;
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (mul_rsp.done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exp_q == '0) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end else if (exp_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mul_rsp.done) begin
						// bit consumed, squaring comes next unless nothing is left
						exp_q[0] <= 1'b0;
						state_q  <= ST_STEP;
					end
				end
				ST_SQR: begin
					if (mul_rsp.done) begin
						exp_q   <= exp_q >> 1;
						state_q <= ST_STEP;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			acc_q <= WORD_BITS'(1);
		end
		if (mul_rsp.done) begin
			if (state_q == ST_MUL) begin
				acc_q <= mul_rsp.prod;
			end else begin
				pow_q <= mul_rsp.prod;
			end
		end
		if (finish && out_free) begin
			out_q <= acc_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_beat) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_BITS'(out_q);

endmodule

FILE: rtl/mexp_checker.sv
// port-level checks of the modular exponentiation block, bound to the top level
// depends on mexp_pkg and modular_exponentiation_assert.svh
`include "modular_exponentiation_assert.svh"

module mexp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [mexp_pkg::DATA_BITS-1:0] m_axis_tdata
);
	import mexp_pkg::*;

	logic in_beat;

	assign in_beat = s_axis_tvalid && s_axis_tready;

	// a base beat keeps the block busy in the next cycle
	`MEXP_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready)
	// no result can appear in the cycle after a base beat
	`MEXP_ASSERT_NEXT(a_no_instant_result, in_beat, !$rose(m_axis_tvalid))
	// a result appears only at the end of a busy period
	`MEXP_ASSERT_NOW(a_result_after_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))
	// a stalled result beat holds its data
	`MEXP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

FILE: bench/modular_exponentiation_checker.sv
`timescale 1ns / 100ps
// checker for the modular exponentiation block: watches the cfg, input and output beats
// predicts each power and compares it with the returned beat; depends on mexp_pkg
module modular_exponentiation_checker
	import mexp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [DATA_BITS-1:0]      s_axis_tdata,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [DATA_BITS-1:0]      m_axis_tdata,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [DATA_BITS-1:0]      cfg_data,
	output int                        pending,
	output int                        fail_count
);

	localparam logic [63:0] WORD_MASK = (64'd1 << WORD_BITS) - 64'd1;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] exponent_q;
	logic [WORD_BITS-1:0] expected_powers[$];
	int                   mismatches;

	assign fail_count = mismatches;

	// modulus zero means plain wraparound at the word width
	function automatic logic [63:0] reduce_mod(input logic [63:0] value, input logic [63:0] m);
		if (m == 64'd0)
			return value & WORD_MASK;
		return value % m;
	endfunction

	// right-to-left square and multiply, products at 64 bits
	function automatic logic [WORD_BITS-1:0] mod_power(input logic [WORD_BITS-1:0] base,
			input logic [WORD_BITS-1:0] exp_bits, input logic [WORD_BITS-1:0] modulus);
		logic [63:0] m;
		logic [63:0] acc;
		logic [63:0] pow;
		m = 64'(modulus);
		acc = 64'd1;
		pow = reduce_mod(64'(base), m);
		for (int i = 0; i < WORD_BITS; i++) begin
			if (exp_bits[i])
				acc = reduce_mod(acc * pow, m);
			pow = reduce_mod(pow * pow, m);
		end
		return acc[WORD_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
			input logic [WORD_BITS-1:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q = WORD_BITS'(1);
			exponent_q = '0;
			expected_powers.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_powers.size() == 0)
					report_mismatch("power_result without a base", m_axis_tdata[WORD_BITS-1:0], '0);
				else if (m_axis_tdata[WORD_BITS-1:0] !== expected_powers[0])
					report_mismatch("power_result", m_axis_tdata[WORD_BITS-1:0], expected_powers[0]);
				if (expected_powers.size() != 0)
					void'(expected_powers.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODULUS: modulus_q = cfg_data[WORD_BITS-1:0];
					CFG_EXPONENT: exponent_q = cfg_data[WORD_BITS-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_powers.push_back(mod_power(s_axis_tdata[WORD_BITS-1:0], exponent_q,
					modulus_q));
			pending <= expected_powers.size();
		end
	end

endmodule

FILE: bench/modular_exponentiation_tb.sv
`timescale 1ns / 100ps
// testbench top of the modular exponentiation block: clock, reset, cfg writes and base beats
// depends on mexp_pkg, modular_exponentiation and modular_exponentiation_checker
module modular_exponentiation_tb;
	import mexp_pkg::*;

	// watchdog limit for the whole run, sized for the slowest items with headroom for stalls and gaps
	localparam int CYCLE_LIMIT = 3_000_000;
	// longest single item plus margin, waited out at the very end
	localparam int DRAIN_CYCLES = 2400;
	localparam int RANDOM_BASES = 250;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [DATA_BITS-1:0]      s_axis_tdata;   // base_value
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [DATA_BITS-1:0]      m_axis_tdata;   // power_result
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [DATA_BITS-1:0]      cfg_data;

	int pending;
	int fail_count;
	int cycle_count;
	int bases_sent;
	bit no_idle;
	logic [WORD_BITS-1:0] cur_modulus;

	modular_exponentiation DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	modular_exponentiation_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog on the whole run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// output side: ready drops at random about 8 times in a hundred, never during the steady stretch
	always @(negedge clk)
		m_axis_tready <= no_idle || ($urandom_range(99) >= 8);

	// one base beat; valid only drops for a gap, so back to back beats keep it high
	task automatic send_base(input logic [WORD_BITS-1:0] base);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DATA_BITS'(base);
		do @(posedge clk); while (!s_axis_tready);
		bases_sent++;
	endtask

	// park the input side and wait until every expected power has come back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// registers only change with nothing in flight
	task automatic set_config(input logic [WORD_BITS-1:0] modulus,
			input logic [WORD_BITS-1:0] exp_bits);
		wait_drained();
		write_reg(CFG_MODULUS, DATA_BITS'(modulus));
		write_reg(CFG_EXPONENT, DATA_BITS'(exp_bits));
		cur_modulus = modulus;
	endtask

	function automatic logic [WORD_BITS-1:0] pick_modulus();
		case ($urandom_range(9))
			0: return '0;
			1: return WORD_BITS'(1);
			2: return '1;
			3: return WORD_BITS'($urandom_range(255, 2));
			4: return WORD_BITS'(1) << (WORD_BITS - 1);
			5: return WORD_BITS'($urandom_range(65535, 256));
			default: return WORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_exponent();
		case ($urandom_range(9))
			0: return '0;
			1: return WORD_BITS'(1);
			2: return '1;
			3: return WORD_BITS'($urandom_range(64, 2));
			4: return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
			default: return WORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_base();
		case ($urandom_range(11))
			0: return '0;
			1: return WORD_BITS'(1);
			2: return '1;
			3: return cur_modulus - WORD_BITS'(1);
			4: return cur_modulus;
			default: return WORD_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int phase_len;
		// every input known from time zero
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODULUS;
		cfg_data = '0;
		no_idle = 1'b0;
		bases_sent = 0;
		cur_modulus = WORD_BITS'(1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: modulus 1 and exponent zero still give 1
		send_base('0);
		send_base('1);

		// largest modulus and exponent, extreme bases
		set_config('1, '1);
		send_base('0);
		send_base(WORD_BITS'(1));
		send_base('1 - WORD_BITS'(1));
		send_base('1);
		send_base(WORD_BITS'(32'h1234_5678));

		// modulus zero wraps at the word width
		set_config('0, '1);
		send_base(WORD_BITS'(3));
		send_base('1);
		set_config('0, WORD_BITS'(2));
		send_base(WORD_BITS'(32'h0001_0000));
		send_base('1);

		// modulus 1 with a nonzero exponent reduces everything to zero
		set_config(WORD_BITS'(1), WORD_BITS'(5));
		send_base(WORD_BITS'(7));
		send_base('1);

		// exponent zero written explicitly
		set_config(WORD_BITS'(1), '0);
		send_base(WORD_BITS'(9));

		// exponent 1 shows the initial reduction of the base
		set_config(WORD_BITS'(1_000_003), WORD_BITS'(1));
		send_base('1);
		send_base(WORD_BITS'(1_000_003));
		send_base(WORD_BITS'(1_000_002));

		// top bits only
		set_config(WORD_BITS'(1) << (WORD_BITS - 1), WORD_BITS'(1) << (WORD_BITS - 1));
		send_base(WORD_BITS'(3));
		send_base(WORD_BITS'(32'hAAAA_AAAA));

		// random phases, each under its own register setting
		while (bases_sent < RANDOM_BASES + 19) begin
			set_config(pick_modulus(), pick_exponent());
			phase_len = $urandom_range(24, 8);
			for (int i = 0; i < phase_len; i++) begin
				// a stretch with no gaps or stalls on either side
				no_idle = (bases_sent >= 110 && bases_sent < 160);
				send_base(pick_base());
			end
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
bench/modular_exponentiation_checker.sv
bench/modular_exponentiation_tb.sv
